/* design/nlt_pkg.sv */
// Shared types, codes and constants for the namespace lock table.
`default_nettype none
package nlt_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int ID_W            = 32;
  localparam int KEY_W           = 64;
  localparam int NUM_KEY_REGS    = 4;
  localparam int CFG_IDX_W       = 8;
  localparam int MODE_W          = 2;
  localparam int STATUS_W        = 3;
  localparam int FUNC_W          = 2;
  localparam int ENTRY_W         = ID_W + MODE_W;
  localparam int TOKEN_BYTES     = 32;
  localparam int IN_DATA_W       = ID_W + NUM_KEY_REGS * KEY_W;
  localparam int OUT_DATA_W      = 8;

  localparam logic [7:0] TOK_XOR  = 8'hA5;
  localparam logic [7:0] TOK_STEP = 8'h37;

  localparam logic [FUNC_W-1:0] FN_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOCK     = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UNLOCK   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_EMPTY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCKED = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOROOM   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_AUTH     = 3'd5;

  typedef struct packed {
    logic clr_we;
    logic rd_en;
    logic start;
    logic commit;
  } nlt_cmd_t;

endpackage
`default_nettype wire

/* design/nlt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nlt_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire [AW-1:0]           waddr,
  input  wire [WIDTH-1:0]        wdata,
  input  wire                    re,
  input  wire [AW-1:0]           raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule
`default_nettype wire

/* design/nlt_ctrl.sv */
// Controller: clearing pass, table scan sequencing and result hand-off.
`default_nettype none
module nlt_ctrl #(
  parameter  int NUM_ENTRIES = nlt_pkg::NUM_ENTRIES_DEF,
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire                 out_busy,
  output nlt_pkg::nlt_cmd_t   cmd,
  output logic [IDX_W-1:0]    idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last;

  assign last = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (last) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (last) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          idx_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule
`default_nettype wire

/* design/nlt_dp.sv */
// Datapath: key registers, entry RAM, scan trackers, token check and result register.
`default_nettype none
module nlt_dp #(
  parameter  int NUM_ENTRIES = nlt_pkg::NUM_ENTRIES_DEF,
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire nlt_pkg::nlt_cmd_t           cmd,
  input  wire [IDX_W-1:0]                  idx,
  output logic                             out_busy,
  input  wire                              cfg_we,
  input  wire [nlt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [nlt_pkg::KEY_W-1:0]         cfg_data,
  input  wire [nlt_pkg::FUNC_W-1:0]        in_func,
  input  wire [nlt_pkg::IN_DATA_W-1:0]     in_data,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [nlt_pkg::STATUS_W-1:0]     out_status,
  output logic                             out_locked
);

  logic [nlt_pkg::NUM_KEY_REGS-1:0][nlt_pkg::KEY_W-1:0] key_r;
  logic [nlt_pkg::NUM_KEY_REGS-1:0][nlt_pkg::KEY_W-1:0] tok_r;
  logic [nlt_pkg::FUNC_W-1:0]    func_r;
  logic [nlt_pkg::ID_W-1:0]      id_r;

  logic                          rd_vld_r;
  logic [IDX_W-1:0]              rd_idx_r;
  logic [nlt_pkg::ENTRY_W-1:0]   rd_entry;
  logic [nlt_pkg::ID_W-1:0]      rd_ns;
  logic [nlt_pkg::MODE_W-1:0]    rd_mode;

  logic                          fm_found_r;
  logic [IDX_W-1:0]              fm_idx_r;
  logic [nlt_pkg::MODE_W-1:0]    fm_mode_r;
  logic                          ex_r;
  logic                          em_found_r;
  logic [IDX_W-1:0]              em_idx_r;

  logic                          auth_ok;
  logic [nlt_pkg::STATUS_W-1:0]  st;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;
  logic [nlt_pkg::MODE_W-1:0]    wr_mode;
  logic [nlt_pkg::MODE_W-1:0]    mode_after;
  logic                          locked_nxt;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [nlt_pkg::ENTRY_W-1:0]   ram_wdata;

  logic                          out_valid_r;
  logic [nlt_pkg::STATUS_W-1:0]  out_status_r;
  logic                          out_locked_r;

  // master key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we && (cfg_index < nlt_pkg::CFG_IDX_W'(nlt_pkg::NUM_KEY_REGS))) begin
      key_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r <= in_func;
      id_r   <= in_data[nlt_pkg::ID_W-1:0];
      tok_r  <= in_data[nlt_pkg::IN_DATA_W-1:nlt_pkg::ID_W];
    end
  end

  assign ram_we    = cmd.clr_we || (cmd.commit && wr_en);
  assign ram_waddr = cmd.clr_we ? idx : wr_idx;
  assign ram_wdata = cmd.clr_we ? '0 : {id_r, wr_mode};

  nlt_ram #(
    .WIDTH (nlt_pkg::ENTRY_W),
    .DEPTH (NUM_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (rd_entry)
  );

  assign rd_ns   = rd_entry[nlt_pkg::ENTRY_W-1:nlt_pkg::MODE_W];
  assign rd_mode = rd_entry[nlt_pkg::MODE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
    rd_idx_r <= idx;
  end

  // scan trackers: first id match, any live match, first empty entry
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      fm_found_r <= 1'b0;
      ex_r       <= 1'b0;
      em_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_ns == id_r && !fm_found_r) begin
        fm_found_r <= 1'b1;
      end
      if (rd_ns == id_r && rd_mode != nlt_pkg::MODE_EMPTY) begin
        ex_r <= 1'b1;
      end
      if (rd_mode == nlt_pkg::MODE_EMPTY && !em_found_r) begin
        em_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && rd_ns == id_r && !fm_found_r) begin
      fm_idx_r  <= rd_idx_r;
      fm_mode_r <= rd_mode;
    end
    if (rd_vld_r && rd_mode == nlt_pkg::MODE_EMPTY && !em_found_r) begin
      em_idx_r <= rd_idx_r;
    end
  end

  // token check, 32 independent byte compares
  always_comb begin
    logic [7:0] exp_b;
    auth_ok = 1'b1;
    for (int i = 0; i < nlt_pkg::TOKEN_BYTES; i++) begin
      exp_b = (key_r[i / 8][8 * (i % 8) +: 8] ^ nlt_pkg::TOK_XOR ^ id_r[8 * (i % 4) +: 8])
              + 8'(nlt_pkg::TOK_STEP * i);
      if (exp_b != tok_r[i / 8][8 * (i % 8) +: 8]) begin
        auth_ok = 1'b0;
      end
    end
  end

  // outcome
  always_comb begin
    st      = nlt_pkg::ST_INVALID;
    wr_en   = 1'b0;
    wr_idx  = fm_idx_r;
    wr_mode = fm_mode_r;
    if (id_r != '0) begin
      unique case (func_r)
        nlt_pkg::FN_REGISTER: begin
          if (ex_r) begin
            st = nlt_pkg::ST_EXISTS;
          end else if (!em_found_r) begin
            st = nlt_pkg::ST_NOROOM;
          end else begin
            st      = nlt_pkg::ST_OK;
            wr_en   = 1'b1;
            wr_idx  = em_idx_r;
            wr_mode = nlt_pkg::MODE_ACTIVE;
          end
        end
        nlt_pkg::FN_LOCK: begin
          if (!fm_found_r) begin
            st = nlt_pkg::ST_NOTFOUND;
          end else if (fm_mode_r == nlt_pkg::MODE_ACTIVE) begin
            st      = nlt_pkg::ST_OK;
            wr_en   = 1'b1;
            wr_mode = nlt_pkg::MODE_LOCKED;
          end else if (fm_mode_r == nlt_pkg::MODE_LOCKED) begin
            st = nlt_pkg::ST_OK;
          end else begin
            st = nlt_pkg::ST_INVALID;
          end
        end
        nlt_pkg::FN_UNLOCK: begin
          if (!auth_ok) begin
            st = nlt_pkg::ST_AUTH;
          end else if (!fm_found_r) begin
            st = nlt_pkg::ST_NOTFOUND;
          end else if (fm_mode_r == nlt_pkg::MODE_ACTIVE) begin
            st = nlt_pkg::ST_OK;
          end else if (fm_mode_r == nlt_pkg::MODE_LOCKED) begin
            st      = nlt_pkg::ST_OK;
            wr_en   = 1'b1;
            wr_mode = nlt_pkg::MODE_ACTIVE;
          end else begin
            st = nlt_pkg::ST_INVALID;
          end
        end
        default: begin
          st = nlt_pkg::ST_INVALID;
        end
      endcase
    end
  end

  assign mode_after = wr_en ? wr_mode : fm_mode_r;
  assign locked_nxt = (id_r != '0) && fm_found_r && (mode_after == nlt_pkg::MODE_LOCKED);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= st;
      out_locked_r <= locked_nxt;
    end
  end

  assign out_busy   = out_valid_r && !out_tready;
  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_locked = out_locked_r;

endmodule
`default_nettype wire

/* design/namespace_lock_table.sv */
// Top level of the namespace lock table.
//
//  channel | direction | tdata / tuser / payload
//  in_     | slave     | tdata: ns_id, token_0..3; tuser: func
//  out_    | master    | tdata: status, locked, zero pad
//  cfg_    | write     | cfg_index, cfg_data (master key words)
//
// For each request the entry RAM is scanned one entry per cycle through its
// single read port; the last read is then drained, and a decide step writes
// back and registers the result.
// After reset a clearing pass empties the RAM; no request is taken meanwhile,
// configuration writes are. While a result waits in the output register one
// more request is taken and holds in its decide step.
`default_nettype none
module namespace_lock_table #(
  parameter int NUM_ENTRIES = nlt_pkg::NUM_ENTRIES_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // in_tdata, from bit 0: ns_id[31:0], token_0, token_1, token_2, token_3
  input  wire [nlt_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser, from bit 0: func[1:0]
  input  wire [nlt_pkg::FUNC_W-1:0]      in_tuser,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // out_tdata, from bit 0: status[2:0], locked, zero pad
  output logic [nlt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [nlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [nlt_pkg::KEY_W-1:0]       cfg_data
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  nlt_pkg::nlt_cmd_t             cmd;
  logic [IDX_W-1:0]              idx;
  logic                          out_busy;
  logic [nlt_pkg::STATUS_W-1:0]  out_status;
  logic                          out_locked;

  assign cfg_ready = 1'b1;

  nlt_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_busy  (out_busy),
    .cmd       (cmd),
    .idx       (idx)
  );

  nlt_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .idx        (idx),
    .out_busy   (out_busy),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_func    (in_tuser),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_locked (out_locked)
  );

  assign out_tdata = {{(nlt_pkg::OUT_DATA_W - nlt_pkg::STATUS_W - 1){1'b0}},
                      out_locked, out_status};

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_tvalid && !out_tready))
    else $error("result committed over a pending transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while another is in flight");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed result not presented");

  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_we |-> !(cmd.rd_en || cmd.commit || in_tready))
    else $error("clearing pass overlaps request work");
`endif

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking bench for the namespace lock table: directed table, then random traffic.
module tb;

  localparam int N_ENT          = nlt_pkg::NUM_ENTRIES_DEF;
  localparam int LATENCY        = N_ENT + 3;
  localparam int DRAIN_CYCLES   = 4 * LATENCY;
  localparam int STALL_LIMIT    = 4000;
  localparam int RAND_PER_PHASE = 225;
  localparam int NUM_PHASES     = 4;
  localparam int POOL_SIZE      = 24;
  localparam int PRESSURE_AT    = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int TOK_W          = nlt_pkg::TOKEN_BYTES * 8;

  localparam logic [nlt_pkg::FUNC_W-1:0]    FN_RESERVED      = 2'd3;
  localparam logic [nlt_pkg::CFG_IDX_W-1:0] REG_MASTER_KEY_0 = 8'd0;

  typedef struct packed {
    logic                         locked;
    logic [nlt_pkg::STATUS_W-1:0] status;
  } lock_result_t;

  typedef enum logic [1:0] {TK_ZERO, TK_ONES, TK_GOOD, TK_BAD} tok_sel_t;

  typedef struct packed {
    logic [nlt_pkg::FUNC_W-1:0] fn;
    logic [nlt_pkg::ID_W-1:0]   id;
    tok_sel_t                   tk;
    logic                       typed;
    lock_result_t               want;
  } dir_row_t;

  localparam int NUM_DIR = 21;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{nlt_pkg::FN_REGISTER, 32'h0000_0000, TK_ZERO, 1'b1, '{1'b0, nlt_pkg::ST_INVALID}},
    '{nlt_pkg::FN_LOCK,     32'h0000_0000, TK_ONES, 1'b1, '{1'b0, nlt_pkg::ST_INVALID}},
    '{nlt_pkg::FN_UNLOCK,   32'h0000_0000, TK_GOOD, 1'b1, '{1'b0, nlt_pkg::ST_INVALID}},
    '{FN_RESERVED,          32'h0000_0005, TK_ZERO, 1'b1, '{1'b0, nlt_pkg::ST_INVALID}},
    '{nlt_pkg::FN_REGISTER, 32'hFFFF_FFFF, TK_ONES, 1'b1, '{1'b0, nlt_pkg::ST_OK}},
    '{nlt_pkg::FN_REGISTER, 32'hFFFF_FFFF, TK_ZERO, 1'b1, '{1'b0, nlt_pkg::ST_EXISTS}},
    '{nlt_pkg::FN_LOCK,     32'hFFFF_FFFF, TK_ZERO, 1'b1, '{1'b1, nlt_pkg::ST_OK}},
    '{nlt_pkg::FN_LOCK,     32'hFFFF_FFFF, TK_ONES, 1'b1, '{1'b1, nlt_pkg::ST_OK}},
    '{FN_RESERVED,          32'hFFFF_FFFF, TK_ONES, 1'b1, '{1'b1, nlt_pkg::ST_INVALID}},
    '{nlt_pkg::FN_UNLOCK,   32'hFFFF_FFFF, TK_BAD,  1'b1, '{1'b1, nlt_pkg::ST_AUTH}},
    '{nlt_pkg::FN_UNLOCK,   32'h0000_0001, TK_ONES, 1'b0, '{1'b0, nlt_pkg::ST_OK}},
    '{nlt_pkg::FN_UNLOCK,   32'h0000_0001, TK_GOOD, 1'b1, '{1'b0, nlt_pkg::ST_NOTFOUND}},
    '{nlt_pkg::FN_UNLOCK,   32'hFFFF_FFFF, TK_GOOD, 1'b1, '{1'b0, nlt_pkg::ST_OK}},
    '{nlt_pkg::FN_UNLOCK,   32'hFFFF_FFFF, TK_GOOD, 1'b1, '{1'b0, nlt_pkg::ST_OK}},
    '{nlt_pkg::FN_LOCK,     32'h0000_0001, TK_ZERO, 1'b1, '{1'b0, nlt_pkg::ST_NOTFOUND}},
    '{nlt_pkg::FN_REGISTER, 32'h0000_0001, TK_ZERO, 1'b1, '{1'b0, nlt_pkg::ST_OK}},
    '{nlt_pkg::FN_REGISTER, 32'h8000_0000, TK_ONES, 1'b1, '{1'b0, nlt_pkg::ST_OK}},
    '{nlt_pkg::FN_LOCK,     32'h0000_0001, TK_ZERO, 1'b1, '{1'b1, nlt_pkg::ST_OK}},
    '{nlt_pkg::FN_REGISTER, 32'h0000_0001, TK_ZERO, 1'b1, '{1'b1, nlt_pkg::ST_EXISTS}},
    '{nlt_pkg::FN_UNLOCK,   32'h8000_0000, TK_BAD,  1'b1, '{1'b0, nlt_pkg::ST_AUTH}},
    '{nlt_pkg::FN_UNLOCK,   32'h0000_0001, TK_GOOD, 1'b1, '{1'b0, nlt_pkg::ST_OK}}
  };

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic [nlt_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [nlt_pkg::FUNC_W-1:0]     in_tuser   = '0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [nlt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [nlt_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [nlt_pkg::KEY_W-1:0]      cfg_data   = '0;

  namespace_lock_table #(.NUM_ENTRIES(N_ENT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [TOK_W-1:0]           master_key;
  logic [nlt_pkg::ID_W-1:0]   tbl_ns   [N_ENT];
  logic [nlt_pkg::MODE_W-1:0] tbl_mode [N_ENT];

  lock_result_t lock_results_q [$];
  int           fail_count = 0;
  int           in_count   = 0;
  int           out_count  = 0;
  int           stall_cnt  = 0;
  int           hold_left  = 0;
  logic         held       = 1'b0;
  logic [nlt_pkg::ID_W-1:0] id_pool [POOL_SIZE];

  // no idling on either side for a stretch of the run
  wire calm = (in_count >= 600) && (in_count < 750);

  function automatic logic [TOK_W-1:0] unlock_token(input logic [nlt_pkg::ID_W-1:0] id);
    logic [TOK_W-1:0] t;
    logic [7:0]       b;
    for (int i = 0; i < nlt_pkg::TOKEN_BYTES; i++) begin
      b = (master_key[i*8 +: 8] ^ nlt_pkg::TOK_XOR ^ id[(i % 4)*8 +: 8])
          + 8'(nlt_pkg::TOK_STEP * i);
      t[i*8 +: 8] = b;
    end
    return t;
  endfunction

  function automatic logic [TOK_W-1:0] rand_token();
    logic [TOK_W-1:0] t;
    for (int w = 0; w < TOK_W / 32; w++) t[w*32 +: 32] = $urandom;
    return t;
  endfunction

  function automatic int find_ns(input logic [nlt_pkg::ID_W-1:0] id);
    for (int i = 0; i < N_ENT; i++) if (tbl_ns[i] == id) return i;
    return -1;
  endfunction

  function automatic lock_result_t predict_result(input logic [nlt_pkg::FUNC_W-1:0] fn,
                                                  input logic [nlt_pkg::ID_W-1:0] id,
                                                  input logic [TOK_W-1:0] tok);
    lock_result_t r;
    int           e;
    int           slot;
    r.status = nlt_pkg::ST_INVALID;
    r.locked = 1'b0;
    slot     = -1;
    if (id != '0) begin
      e = find_ns(id);
      case (fn)
        nlt_pkg::FN_REGISTER: begin
          r.status = nlt_pkg::ST_OK;
          for (int i = 0; i < N_ENT; i++)
            if (tbl_ns[i] == id && tbl_mode[i] != nlt_pkg::MODE_EMPTY)
              r.status = nlt_pkg::ST_EXISTS;
          if (r.status == nlt_pkg::ST_OK) begin
            for (int i = 0; i < N_ENT; i++)
              if (slot < 0 && tbl_mode[i] == nlt_pkg::MODE_EMPTY) slot = i;
            if (slot < 0) begin
              r.status = nlt_pkg::ST_NOROOM;
            end else begin
              tbl_ns[slot]   = id;
              tbl_mode[slot] = nlt_pkg::MODE_ACTIVE;
            end
          end
        end
        nlt_pkg::FN_LOCK: begin
          if (e < 0) begin
            r.status = nlt_pkg::ST_NOTFOUND;
          end else if (tbl_mode[e] == nlt_pkg::MODE_ACTIVE) begin
            tbl_mode[e] = nlt_pkg::MODE_LOCKED;
            r.status    = nlt_pkg::ST_OK;
          end else if (tbl_mode[e] == nlt_pkg::MODE_LOCKED) begin
            r.status = nlt_pkg::ST_OK;
          end
        end
        nlt_pkg::FN_UNLOCK: begin
          if (tok != unlock_token(id)) begin
            r.status = nlt_pkg::ST_AUTH;
          end else if (e < 0) begin
            r.status = nlt_pkg::ST_NOTFOUND;
          end else if (tbl_mode[e] == nlt_pkg::MODE_ACTIVE) begin
            r.status = nlt_pkg::ST_OK;
          end else if (tbl_mode[e] == nlt_pkg::MODE_LOCKED) begin
            tbl_mode[e] = nlt_pkg::MODE_ACTIVE;
            r.status    = nlt_pkg::ST_OK;
          end
        end
        default: ;
      endcase
      e = find_ns(id);
      if (e >= 0) r.locked = (tbl_mode[e] == nlt_pkg::MODE_LOCKED);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
             $realtime, out_count, what, got, want);
    fail_count++;
  endtask

  task automatic write_master_key(input logic [TOK_W-1:0] k);
    cfg_valid <= 1'b1;
    for (int r = 0; r < nlt_pkg::NUM_KEY_REGS; r++) begin
      cfg_index <= REG_MASTER_KEY_0 + nlt_pkg::CFG_IDX_W'(r);
      cfg_data  <= k[r*nlt_pkg::KEY_W +: nlt_pkg::KEY_W];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    master_key = k;
  endtask

  task automatic send_req(input logic [nlt_pkg::FUNC_W-1:0] fn,
                          input logic [nlt_pkg::ID_W-1:0] id,
                          input logic [TOK_W-1:0] tok, input logic typed,
                          input lock_result_t want);
    lock_result_t pred;
    while (!calm && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {tok, id};
    do @(posedge clk); while (!in_tready);
    in_count++;
    pred = predict_result(fn, id, tok);
    lock_results_q.push_back(typed ? want : pred);
  endtask

  // result side: check each transfer, then choose the next ready
  always @(posedge clk) begin
    lock_result_t want;
    if (out_tvalid && out_tready) begin
      if (lock_results_q.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        want = lock_results_q.pop_front();
        if (out_tdata[2:0] !== want.status) report_mismatch("status", out_tdata[2:0], want.status);
        if (out_tdata[3] !== want.locked) report_mismatch("locked", out_tdata[3], want.locked);
        if (out_tdata[7:4] !== '0) report_mismatch("pad", out_tdata[7:4], 0);
      end
      out_count++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!held && out_count >= PRESSURE_AT) begin
      held       = 1'b1;
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [TOK_W-1:0]           new_key;
    logic [TOK_W-1:0]           tok;
    logic [nlt_pkg::ID_W-1:0]   id;
    logic [nlt_pkg::FUNC_W-1:0] fn;
    int                         pick;
    master_key = '0;
    for (int i = 0; i < N_ENT; i++) begin
      tbl_ns[i]   = '0;
      tbl_mode[i] = nlt_pkg::MODE_EMPTY;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      id_pool[i] = $urandom;
      if (id_pool[i] == '0) id_pool[i] = 32'h1;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1:       new_key = '0;
        2:       new_key = '1;
        default: new_key = rand_token();
      endcase
      if (ph > 0) begin
        while (lock_results_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      write_master_key(new_key);

      if (ph == 0) begin
        for (int r = 0; r < NUM_DIR; r++) begin
          case (DIR_ROWS[r].tk)
            TK_ZERO: tok = '0;
            TK_ONES: tok = '1;
            TK_GOOD: tok = unlock_token(DIR_ROWS[r].id);
            default: tok = unlock_token(DIR_ROWS[r].id) ^ (TOK_W'(1) << $urandom_range(TOK_W-1));
          endcase
          send_req(DIR_ROWS[r].fn, DIR_ROWS[r].id, tok, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end
      end

      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if ($urandom_range(99) < 85) begin
          id   = id_pool[$urandom_range(POOL_SIZE-1)];
          pick = $urandom_range(99);
          fn   = (pick < 30) ? nlt_pkg::FN_REGISTER :
                 (pick < 60) ? nlt_pkg::FN_LOCK : nlt_pkg::FN_UNLOCK;
          if (fn != nlt_pkg::FN_UNLOCK) tok = rand_token();
          else if ($urandom_range(99) < 80) tok = unlock_token(id);
          else tok = unlock_token(id) ^ (TOK_W'(1) << $urandom_range(TOK_W-1));
        end else begin
          id  = ($urandom_range(9) == 0) ? '0 : nlt_pkg::ID_W'($urandom);
          fn  = nlt_pkg::FUNC_W'($urandom_range(3));
          tok = rand_token();
        end
        send_req(fn, id, tok, 1'b0, '0);
      end
      in_tvalid <= 1'b0;
    end

    while (lock_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
